### rtl/core/tspd_pkg.sv
// Shared types, constants and helpers for the tiered server pool dispatcher.
package tspd_pkg;

    localparam int NUM_SERVERS        = 8;
    localparam int CLIENTS_PER_SERVER = 8;
    localparam int PIPE_MAX           = 16;

    localparam int NUM_SLOTS = NUM_SERVERS * CLIENTS_PER_SERVER;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SRV_W     = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
    localparam int CLI_W     = (CLIENTS_PER_SERVER > 1) ? $clog2(CLIENTS_PER_SERVER) : 1;
    localparam int TIER_W    = 2;
    localparam int POS_W     = TIER_W + SRV_W;
    localparam int CNT_W     = 5;
    localparam int QUEUE_W   = 16;

    // Operation codes
    localparam logic [1:0] OP_DISPATCH = 2'd0;
    localparam logic [1:0] OP_COMPLETE = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;
    localparam logic [1:0] OP_STOP     = 2'd3;

    // Verdict codes
    localparam logic [2:0] V_ASSIGNED   = 3'd0;
    localparam logic [2:0] V_FAILED_ALL = 3'd1;
    localparam logic [2:0] V_RETRY      = 3'd2;
    localparam logic [2:0] V_WAIT       = 3'd3;
    localparam logic [2:0] V_DONE       = 3'd4;
    localparam logic [2:0] V_REJECTED   = 3'd5;

    // Configuration register indexes
    localparam int         CFG_IDX_W     = 1;
    localparam logic [0:0] CFG_TIER      = 1'd0;
    localparam logic [0:0] CFG_PIPELINE  = 1'd1;
    localparam logic [31:0] PIPELINE_RST = 32'h1111_1111;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] failed_mask;
        logic [7:0] timeout_mask;
        logic       pipeable;
        logic [2:0] server_index;
        logic [2:0] client_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [2:0] granted_server;
        logic [2:0] granted_client;
    } out_item_t;

    // One slot entry of the state memory
    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [QUEUE_W-1:0] queue;
    } slot_t;

    // Access request from the controller to the slot memory
    typedef struct packed {
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        slot_t             wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_SCAN,
        ST_CRD,
        ST_CEV,
        ST_FIN,
        ST_RESP
    } state_t;

    function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] s, input logic [2:0] c);
        slot_of = SLOT_W'(32'(s) * CLIENTS_PER_SERVER + 32'(c));
    endfunction

endpackage

### rtl/core/tiered_server_pool_dispatcher.sv
// Top level: configuration registers, slot memory and dispatch sequencer.
//
//  channel   direction  handshake              payload
//  in        input      in_valid / in_ready    in_item  (tspd_pkg::in_item_t)
//  out       output     out_valid / out_ready  out_item (tspd_pkg::out_item_t)
//  cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time. Complete, start and stop go through read, update and hand-off to
// the output register; rejected slots go straight to the hand-off.
// A dispatch visits up to 32 (tier, server) positions and, at each candidate
// server, reads its client slots one by one through the one memory read port.
// A grant goes straight to the hand-off; a miss is classified first.
// Reset clears active flags, slot written marks and output valid; no sweep.
// A stalled output holds the next result in the sequencer; config is always ready.
module tiered_server_pool_dispatcher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tspd_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tspd_pkg::out_item_t                  out_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tspd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [31:0]                          cfg_data
);

    logic [15:0]         tier_reg;
    logic [31:0]         pipeline_reg;
    tspd_pkg::mem_req_t  mem_req;
    tspd_pkg::slot_t     rd_data;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tier_reg     <= '0;
            pipeline_reg <= tspd_pkg::PIPELINE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tspd_pkg::CFG_TIER:     tier_reg     <= cfg_data[15:0];
                tspd_pkg::CFG_PIPELINE: pipeline_reg <= cfg_data;
                default:                tier_reg     <= tier_reg;
            endcase
        end
    end

    tspd_slot_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    tspd_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .server_tier     (tier_reg),
        .server_pipeline (pipeline_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_item        (out_item),
        .mem_req         (mem_req),
        .rd_data         (rd_data)
    );

endmodule

### rtl/core/tspd_slot_ram.sv
// Slot state memory: count and pipeable queue per client slot, registered read.
module tspd_slot_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tspd_pkg::mem_req_t         req,
    output tspd_pkg::slot_t            rd_data
);

    tspd_pkg::slot_t                   mem [tspd_pkg::NUM_SLOTS];
    logic [tspd_pkg::NUM_SLOTS-1:0]    valid_reg;
    tspd_pkg::slot_t                   data_reg;
    logic                              hit_reg;

    // Storage array and read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        data_reg <= mem[req.rd_addr];
    end

    // Written marks; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            hit_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

### rtl/core/tspd_ctrl.sv
// Sequencer: tier scan, client capacity checks and slot updates.
module tspd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           server_tier,
    input  logic [31:0]           server_pipeline,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tspd_pkg::in_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tspd_pkg::out_item_t   out_item,
    output tspd_pkg::mem_req_t    mem_req,
    input  tspd_pkg::slot_t       rd_data
);

    localparam logic [tspd_pkg::POS_W-1:0] POS_LAST = '1;
    localparam logic [tspd_pkg::CLI_W-1:0] CLI_LAST =
        tspd_pkg::CLI_W'(tspd_pkg::CLIENTS_PER_SERVER - 1);

    tspd_pkg::state_t                 state_reg, state_next;
    tspd_pkg::in_item_t               item_reg, item_next;
    logic [tspd_pkg::NUM_SLOTS-1:0]   active_reg, active_next;
    logic [tspd_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [tspd_pkg::CLI_W-1:0]       cli_reg, cli_next;
    logic [1:0]                       cur_reg, cur_next;
    logic                             fa_reg, fa_next;
    logic                             ta_reg, ta_next;
    logic                             any_reg, any_next;
    tspd_pkg::out_item_t              pend_reg, pend_next;
    logic                             ovalid_reg, ovalid_next;
    tspd_pkg::out_item_t              oitem_reg, oitem_next;

    logic [tspd_pkg::SRV_W-1:0]       srv;
    logic [1:0]                       tier_pos;
    logic [1:0]                       srv_tier;
    logic                             srv_ok;
    logic                             present;
    logic [4:0]                       limit;
    logic [tspd_pkg::SLOT_W-1:0]      scan_slot;
    logic [tspd_pkg::SLOT_W-1:0]      item_slot;
    logic                             capacity;
    logic                             range_bad;

    assign srv       = pos_reg[tspd_pkg::SRV_W-1:0];
    assign tier_pos  = pos_reg[tspd_pkg::POS_W-1 -: 2];
    assign srv_ok    = 32'(srv) < tspd_pkg::NUM_SERVERS;
    assign srv_tier  = server_tier[2*srv +: 2];
    assign present   = srv_ok && (|active_reg[srv*tspd_pkg::CLIENTS_PER_SERVER +:
                                              tspd_pkg::CLIENTS_PER_SERVER]);
    assign scan_slot = tspd_pkg::slot_of(3'(srv), 3'(cli_reg));
    assign item_slot = tspd_pkg::slot_of(item_reg.server_index, item_reg.client_index);
    assign range_bad = (32'(in_item.server_index) >= tspd_pkg::NUM_SERVERS) ||
                       (32'(in_item.client_index) >= tspd_pkg::CLIENTS_PER_SERVER);

    // Per-server limit, capped at the queue depth
    always_comb
    begin
        limit = {1'b0, server_pipeline[4*srv +: 4]};
        if (32'(limit) > tspd_pkg::PIPE_MAX)
        begin
            limit = 5'(tspd_pkg::PIPE_MAX);
        end
    end

    assign capacity = active_reg[scan_slot] && (rd_data.count < limit) &&
                      ((rd_data.count != 5'd1) || rd_data.queue[0]);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= tspd_pkg::ST_IDLE;
            active_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        pos_reg   <= pos_next;
        cli_reg   <= cli_next;
        cur_reg   <= cur_next;
        fa_reg    <= fa_next;
        ta_reg    <= ta_next;
        any_reg   <= any_next;
        pend_reg  <= pend_next;
        oitem_reg <= oitem_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        active_next = active_reg;
        pos_next    = pos_reg;
        cli_next    = cli_reg;
        cur_next    = cur_reg;
        fa_next     = fa_reg;
        ta_next     = ta_reg;
        any_next    = any_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg;
        oitem_next  = oitem_reg;
        in_ready    = 1'b0;
        mem_req     = '0;
        mem_req.rd_addr = tspd_pkg::slot_of(in_item.server_index, in_item.client_index);

        // Output register drains independently
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            tspd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    item_next = in_item;
                    pos_next  = '0;
                    cli_next  = '0;
                    cur_next  = 2'd0;
                    fa_next   = 1'b1;
                    ta_next   = 1'b1;
                    any_next  = 1'b0;
                    pend_next = '0;
                    if (in_item.operation == tspd_pkg::OP_DISPATCH)
                    begin
                        state_next = tspd_pkg::ST_SCAN;
                    end
                    else if (range_bad)
                    begin
                        pend_next.verdict = tspd_pkg::V_REJECTED;
                        state_next = tspd_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = tspd_pkg::ST_OP;
                    end
                end
            end

            tspd_pkg::ST_OP:
            begin
                pend_next.verdict = tspd_pkg::V_DONE;
                mem_req.wr_addr = item_slot;
                case (item_reg.operation)
                    tspd_pkg::OP_COMPLETE:
                    begin
                        if (rd_data.count == '0)
                        begin
                            pend_next.verdict = tspd_pkg::V_REJECTED;
                        end
                        else
                        begin
                            mem_req.wr_en = 1'b1;
                            mem_req.wr_data.count = rd_data.count - 5'd1;
                            mem_req.wr_data.queue = rd_data.queue >> 1;
                        end
                    end
                    tspd_pkg::OP_START:
                    begin
                        active_next[item_slot] = 1'b1;
                        mem_req.wr_en = 1'b1;
                        mem_req.wr_data.count = 5'd1;
                        mem_req.wr_data.queue = {15'd0, item_reg.pipeable};
                    end
                    tspd_pkg::OP_STOP:
                    begin
                        active_next[item_slot] = 1'b0;
                    end
                    default:
                    begin
                        pend_next.verdict = tspd_pkg::V_DONE;
                    end
                endcase
                state_next = tspd_pkg::ST_RESP;
            end

            // One (tier, server) position per cycle, paused while a server's client slots are read
            tspd_pkg::ST_SCAN:
            begin
                if (present && (srv_tier == tier_pos))
                begin
                    any_next = 1'b1;
                    if ((tier_pos != cur_reg) && (!fa_reg || !ta_reg))
                    begin
                        state_next = tspd_pkg::ST_FIN;
                    end
                    else
                    begin
                        cur_next = tier_pos;
                        if (item_reg.failed_mask[srv])
                        begin
                            state_next = (pos_reg == POS_LAST) ? tspd_pkg::ST_FIN
                                                                : tspd_pkg::ST_SCAN;
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            fa_next = 1'b0;
                            if (item_reg.timeout_mask[srv])
                            begin
                                state_next = (pos_reg == POS_LAST) ? tspd_pkg::ST_FIN
                                                                    : tspd_pkg::ST_SCAN;
                                pos_next = pos_reg + 1'b1;
                            end
                            else
                            begin
                                ta_next    = 1'b0;
                                cli_next   = '0;
                                state_next = tspd_pkg::ST_CRD;
                            end
                        end
                    end
                end
                else
                begin
                    state_next = (pos_reg == POS_LAST) ? tspd_pkg::ST_FIN : tspd_pkg::ST_SCAN;
                    pos_next   = pos_reg + 1'b1;
                end
            end

            // Issue read of the client slot
            tspd_pkg::ST_CRD:
            begin
                mem_req.rd_addr = scan_slot;
                state_next = tspd_pkg::ST_CEV;
            end

            // Capacity check, grant write-back
            tspd_pkg::ST_CEV:
            begin
                if (capacity)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = scan_slot;
                    mem_req.wr_data.count = rd_data.count + 5'd1;
                    mem_req.wr_data.queue = rd_data.queue;
                    if (rd_data.count < 5'd16)
                    begin
                        mem_req.wr_data.queue[rd_data.count[3:0]] =
                            rd_data.queue[rd_data.count[3:0]] | item_reg.pipeable;
                    end
                    pend_next.verdict        = tspd_pkg::V_ASSIGNED;
                    pend_next.granted_server = 3'(srv);
                    pend_next.granted_client = 3'(cli_reg);
                    state_next = tspd_pkg::ST_RESP;
                end
                else if (cli_reg == CLI_LAST)
                begin
                    state_next = (pos_reg == POS_LAST) ? tspd_pkg::ST_FIN : tspd_pkg::ST_SCAN;
                    pos_next   = pos_reg + 1'b1;
                end
                else
                begin
                    cli_next   = cli_reg + 1'b1;
                    state_next = tspd_pkg::ST_CRD;
                end
            end

            // No grant: classify the miss
            tspd_pkg::ST_FIN:
            begin
                if (!any_reg)
                begin
                    pend_next.verdict = tspd_pkg::V_WAIT;
                end
                else if (fa_reg)
                begin
                    pend_next.verdict = tspd_pkg::V_FAILED_ALL;
                end
                else if (ta_reg)
                begin
                    pend_next.verdict = tspd_pkg::V_RETRY;
                end
                else
                begin
                    pend_next.verdict = tspd_pkg::V_WAIT;
                end
                state_next = tspd_pkg::ST_RESP;
            end

            // Hand the result to the output register once it is free
            tspd_pkg::ST_RESP:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oitem_next  = pend_reg;
                    state_next  = tspd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tspd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

endmodule

### rtl/core/tspd_checker.sv
// Port-level checks for the dispatcher, bound to the top level.
module tspd_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  tspd_pkg::out_item_t  out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // Grant fields are zero unless assigned
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.verdict != tspd_pkg::V_ASSIGNED) |->
        (out_item.granted_server == 3'd0) && (out_item.granted_client == 3'd0))
        else $error("grant fields set without assignment");

    // Only defined verdict codes
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.verdict <= tspd_pkg::V_REJECTED))
        else $error("undefined verdict");

    // An accepted item keeps the block busy the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

endmodule

bind tiered_server_pool_dispatcher tspd_checker u_tspd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
